### rtl/core/lpht_pkg.sv
package lpht_pkg;

  localparam int unsigned SLOTS     = 64;
  localparam int unsigned SLOT_W    = $clog2(SLOTS);
  localparam int unsigned CNT_W     = SLOT_W + 1;
  localparam int unsigned KEY_BYTES = 8;

  localparam logic [2:0] MODE_PUT    = 3'd0;
  localparam logic [2:0] MODE_FORCE  = 3'd1;
  localparam logic [2:0] MODE_GET    = 3'd2;
  localparam logic [2:0] MODE_DEL    = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;
  localparam logic [2:0] MODE_INVAL  = 3'd5;

  localparam logic [3:0] ST_INSERTED  = 4'd0;
  localparam logic [3:0] ST_UPDATED   = 4'd1;
  localparam logic [3:0] ST_EVICTED   = 4'd2;
  localparam logic [3:0] ST_FOUND     = 4'd3;
  localparam logic [3:0] ST_NOT_FOUND = 4'd4;
  localparam logic [3:0] ST_DELETED   = 4'd5;
  localparam logic [3:0] ST_FULL      = 4'd6;
  localparam logic [3:0] ST_INVALID   = 4'd7;
  localparam logic [3:0] ST_CLEARED   = 4'd8;
  localparam logic [3:0] ST_NO_SLOT   = 4'd9;

  typedef struct packed {
    logic [2:0]        mode;
    logic [SLOT_W-1:0] home_slot;
    logic [63:0]       key;
    logic [3:0]        key_length;
    logic [63:0]       value;
    logic [15:0]       value_length;
  } in_t;

  typedef struct packed {
    logic [3:0]        status;
    logic [63:0]       result_value;
    logic [15:0]       result_value_length;
    logic [63:0]       result_key;
    logic [3:0]        result_key_length;
    logic [SLOT_W-1:0] result_slot;
    logic [CNT_W-1:0]  occupancy;
  } out_t;

  typedef struct packed {
    logic [63:0] key;
    logic [3:0]  key_length;
    logic [63:0] value;
    logic [15:0] value_length;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    entry_t            wdata;
    logic [SLOT_W-1:0] raddr;
  } ram_req_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MOD  = 5'b00010,
    S_RD   = 5'b00100,
    S_EV   = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

endpackage

### rtl/core/lpht_ram.sv
module lpht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/lpht_engine.sv
module lpht_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  lpht_pkg::in_t             in_data,
  output logic                      in_ready,
  input  logic [lpht_pkg::CNT_W-1:0] cap,
  input  logic                      out_free,
  output logic                      done,
  output lpht_pkg::out_t            res,
  output lpht_pkg::ram_req_t        ram_req,
  input  lpht_pkg::entry_t          ram_rdata
);

  lpht_pkg::state_t state_r, state_nxt;
  logic [2:0]                  mode_r, mode_nxt;
  logic [lpht_pkg::SLOT_W-1:0] home_r, home_nxt;
  logic [lpht_pkg::SLOT_W-1:0] s_r, s_nxt;
  logic [lpht_pkg::SLOT_W-1:0] tomb_s_r, tomb_s_nxt;
  logic [lpht_pkg::CNT_W-1:0]  n_r, n_nxt;
  logic [lpht_pkg::CNT_W-1:0]  live_r, live_nxt;
  logic                        tomb_v_r, tomb_v_nxt;
  logic                        full_r, full_nxt;
  logic                        invalid_r, invalid_nxt;
  logic [lpht_pkg::SLOTS-1:0]  used_r, used_nxt;
  logic [lpht_pkg::SLOTS-1:0]  tomb_r, tomb_nxt;
  lpht_pkg::entry_t            ent_r, ent_nxt;
  lpht_pkg::out_t              res_r, res_nxt;

  logic [63:0]                 kmask;
  logic                        match;
  logic                        last;
  logic [lpht_pkg::SLOT_W-1:0] s_inc;
  logic [lpht_pkg::SLOT_W-1:0] tgt;

  assign in_ready = (state_r == lpht_pkg::S_IDLE);
  assign done     = (state_r == lpht_pkg::S_DONE) && out_free;
  assign match    = (ram_rdata.key_length == ent_r.key_length) && (ram_rdata.key == ent_r.key);
  assign last     = (lpht_pkg::CNT_W'(n_r + 1'b1) == cap);
  assign s_inc    = (lpht_pkg::CNT_W'({1'b0, s_r} + 1'b1) == cap) ? '0 : s_r + 1'b1;
  assign tgt      = tomb_v_r ? tomb_s_r : s_r;

  // keep only the valid key bytes
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      kmask[b*8 +: 8] = (4'(b) < in_data.key_length) ? 8'hFF : 8'h00;
    end
  end

  always_comb begin
    res       = res_r;
    res.occupancy = live_r;
  end

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    home_nxt    = home_r;
    s_nxt       = s_r;
    tomb_s_nxt  = tomb_s_r;
    n_nxt       = n_r;
    live_nxt    = live_r;
    tomb_v_nxt  = tomb_v_r;
    full_nxt    = full_r;
    invalid_nxt = invalid_r;
    used_nxt    = used_r;
    tomb_nxt    = tomb_r;
    ent_nxt     = ent_r;
    res_nxt     = res_r;
    ram_req.we    = 1'b0;
    ram_req.waddr = s_r;
    ram_req.wdata = ent_r;
    ram_req.raddr = s_r;

    case (state_r)
      lpht_pkg::S_IDLE: begin
        if (in_valid) begin
          // decode the transfer and settle the cases that need no probe
          res_nxt          = '0;
          res_nxt.status   = lpht_pkg::ST_INVALID;
          mode_nxt         = in_data.mode;
          home_nxt         = in_data.home_slot;
          ent_nxt.key          = in_data.key & kmask;
          ent_nxt.key_length   = in_data.key_length;
          ent_nxt.value        = in_data.value;
          ent_nxt.value_length = in_data.value_length;
          state_nxt        = lpht_pkg::S_DONE;
          if (in_data.mode == lpht_pkg::MODE_INVAL) begin
            used_nxt       = '0;
            tomb_nxt       = '0;
            live_nxt       = '0;
            invalid_nxt    = 1'b1;
            res_nxt.status = lpht_pkg::ST_CLEARED;
          end else if (invalid_r || in_data.mode > lpht_pkg::MODE_INVAL) begin
            res_nxt.status = lpht_pkg::ST_INVALID;
          end else if (in_data.mode == lpht_pkg::MODE_CLEAR) begin
            used_nxt       = '0;
            tomb_nxt       = '0;
            live_nxt       = '0;
            res_nxt.status = lpht_pkg::ST_CLEARED;
          end else if (in_data.key_length == 4'd0 ||
                       in_data.key_length > 4'(lpht_pkg::KEY_BYTES)) begin
            res_nxt.status = lpht_pkg::ST_INVALID;
          end else if (in_data.mode <= lpht_pkg::MODE_FORCE &&
                       in_data.value_length == 16'd0) begin
            res_nxt.status = lpht_pkg::ST_INVALID;
          end else begin
            state_nxt = lpht_pkg::S_MOD;
          end
        end
      end

      lpht_pkg::S_MOD: begin
        // reduce the home slot by repeated subtraction
        if ({1'b0, home_r} >= cap) begin
          home_nxt = home_r - cap[lpht_pkg::SLOT_W-1:0];
        end else begin
          s_nxt           = home_r;
          n_nxt           = '0;
          tomb_v_nxt      = 1'b0;
          full_nxt        = 1'b0;
          res_nxt.result_slot = home_r;
          state_nxt       = lpht_pkg::S_RD;
          if (mode_r <= lpht_pkg::MODE_FORCE && live_r >= cap) begin
            if (mode_r == lpht_pkg::MODE_PUT) begin
              res_nxt.status = lpht_pkg::ST_FULL;
              state_nxt      = lpht_pkg::S_DONE;
            end else begin
              full_nxt = 1'b1;
            end
          end
        end
      end

      lpht_pkg::S_RD: begin
        state_nxt = lpht_pkg::S_EV;
      end

      lpht_pkg::S_EV: begin
        state_nxt = lpht_pkg::S_RD;
        s_nxt     = s_inc;
        n_nxt     = n_r + 1'b1;
        if (full_r) begin
          // forced put on a full table acts on the home slot only
          state_nxt     = lpht_pkg::S_DONE;
          ram_req.we    = 1'b1;
          used_nxt[s_r] = 1'b1;
          tomb_nxt[s_r] = 1'b0;
          if (!used_r[s_r] || tomb_r[s_r]) begin
            live_nxt       = live_r + 1'b1;
            res_nxt.status = lpht_pkg::ST_INSERTED;
          end else if (match) begin
            res_nxt.status = lpht_pkg::ST_UPDATED;
          end else begin
            res_nxt.status              = lpht_pkg::ST_EVICTED;
            res_nxt.result_value        = ram_rdata.value;
            res_nxt.result_value_length = ram_rdata.value_length;
            res_nxt.result_key          = ram_rdata.key;
            res_nxt.result_key_length   = ram_rdata.key_length;
          end
        end else if (mode_r <= lpht_pkg::MODE_FORCE) begin
          if (!used_r[s_r]) begin
            state_nxt           = lpht_pkg::S_DONE;
            ram_req.we          = 1'b1;
            ram_req.waddr       = tgt;
            used_nxt[tgt]       = 1'b1;
            tomb_nxt[tgt]       = 1'b0;
            live_nxt            = live_r + 1'b1;
            res_nxt.status      = lpht_pkg::ST_INSERTED;
            res_nxt.result_slot = tgt;
          end else if (!tomb_r[s_r] && match) begin
            state_nxt           = lpht_pkg::S_DONE;
            ram_req.we          = 1'b1;
            res_nxt.status      = lpht_pkg::ST_UPDATED;
            res_nxt.result_slot = s_r;
          end else begin
            if (tomb_r[s_r] && !tomb_v_r) begin
              tomb_v_nxt = 1'b1;
              tomb_s_nxt = s_r;
            end
            if (last) begin
              state_nxt = lpht_pkg::S_DONE;
              if (tomb_v_r || tomb_r[s_r]) begin
                ram_req.we          = 1'b1;
                ram_req.waddr       = tomb_v_r ? tomb_s_r : s_r;
                used_nxt[ram_req.waddr] = 1'b1;
                tomb_nxt[ram_req.waddr] = 1'b0;
                live_nxt            = live_r + 1'b1;
                res_nxt.status      = lpht_pkg::ST_INSERTED;
                res_nxt.result_slot = ram_req.waddr;
              end else begin
                res_nxt.status = lpht_pkg::ST_NO_SLOT;
              end
            end
          end
        end else begin
          // get and delete stop at a never-used slot
          if (!used_r[s_r]) begin
            state_nxt      = lpht_pkg::S_DONE;
            res_nxt.status = lpht_pkg::ST_NOT_FOUND;
          end else if (!tomb_r[s_r] && match) begin
            state_nxt                   = lpht_pkg::S_DONE;
            res_nxt.result_value        = ram_rdata.value;
            res_nxt.result_value_length = ram_rdata.value_length;
            res_nxt.result_key          = ram_rdata.key;
            res_nxt.result_key_length   = ram_rdata.key_length;
            res_nxt.result_slot         = s_r;
            if (mode_r == lpht_pkg::MODE_DEL) begin
              tomb_nxt[s_r]  = 1'b1;
              if (live_r != '0) begin
                live_nxt = live_r - 1'b1;
              end
              res_nxt.status = lpht_pkg::ST_DELETED;
            end else begin
              res_nxt.status = lpht_pkg::ST_FOUND;
            end
          end else if (last) begin
            state_nxt      = lpht_pkg::S_DONE;
            res_nxt.status = lpht_pkg::ST_NOT_FOUND;
          end
        end
      end

      lpht_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = lpht_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = lpht_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lpht_pkg::S_IDLE;
      live_r    <= '0;
      invalid_r <= 1'b0;
      used_r    <= '0;
      tomb_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      live_r    <= live_nxt;
      invalid_r <= invalid_nxt;
      used_r    <= used_nxt;
      tomb_r    <= tomb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    home_r   <= home_nxt;
    s_r      <= s_nxt;
    tomb_s_r <= tomb_s_nxt;
    n_r      <= n_nxt;
    tomb_v_r <= tomb_v_nxt;
    full_r   <= full_nxt;
    ent_r    <= ent_nxt;
    res_r    <= res_nxt;
  end

endmodule

### rtl/core/linear_probe_hash_table.sv
// Sequence: clear, invalidate and rejected items go straight to the result; otherwise
//   the home slot is reduced by repeated subtraction of the capacity, then slots are probed.
// Throughput: one item at a time; each probe is a read and evaluate pair on
//   the entry memory's registered read port.
// Reset (rst_n, synchronous): used and tombstone marks, live count and the
//   invalid flag clear at once; capacity returns to 64; no clearing pass.
module linear_probe_hash_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  lpht_pkg::in_t              in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output lpht_pkg::out_t             out_data,
  input  logic                       cfg_we,
  input  logic [lpht_pkg::CNT_W-1:0] cfg_wdata
);

  logic [lpht_pkg::CNT_W-1:0] cap_r;
  logic [lpht_pkg::CNT_W-1:0] cap_eff;
  logic                       out_valid_r;
  lpht_pkg::out_t             out_data_r;
  logic                       out_free;
  logic                       done;
  lpht_pkg::out_t             res;
  lpht_pkg::ram_req_t         ram_req;
  lpht_pkg::entry_t           ram_rdata;

  // clamp the capacity register to 1..SLOTS
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = lpht_pkg::CNT_W'(1);
    end else if (cap_r > lpht_pkg::CNT_W'(lpht_pkg::SLOTS)) begin
      cap_eff = lpht_pkg::CNT_W'(lpht_pkg::SLOTS);
    end else begin
      cap_eff = cap_r;
    end
  end

  // hold the capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lpht_pkg::CNT_W'(lpht_pkg::SLOTS);
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  lpht_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .cap       (cap_eff),
    .out_free  (out_free),
    .done      (done),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  lpht_ram #(
    .WIDTH (lpht_pkg::ENTRY_W),
    .DEPTH (lpht_pkg::SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // hold the result until its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.occupancy <= lpht_pkg::CNT_W'(lpht_pkg::SLOTS)))
    else $error("occupancy above slot count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_data))
    else $error("pending result overwritten");

  a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cap_eff != '0) && (cap_eff <= lpht_pkg::CNT_W'(lpht_pkg::SLOTS)))
    else $error("capacity out of range");

endmodule
